// ===== rtl/sdh_pkg.sv =====
// Package for the SPI-mode SD sector host: request codes, phases, shared types.
// No dependencies; used by sdh_seq, sd_spi_sector_host and the testbench.
`default_nettype none
package sdh_pkg;
    localparam int SECTOR_BYTES = 512;
    localparam int IDLE_BYTES   = 10;
    localparam int IDX_W        = 10;

    localparam logic [2:0] REQ_OPEN  = 3'd0;
    localparam logic [2:0] REQ_READ  = 3'd1;
    localparam logic [2:0] REQ_WRITE = 3'd2;
    localparam logic [2:0] REQ_CLOSE = 3'd3;
    localparam logic [2:0] REQ_XCHG  = 3'd4;

    localparam logic [7:0] CMD_GO_IDLE = 8'd0;
    localparam logic [7:0] CMD_INIT    = 8'd1;
    localparam logic [7:0] CMD_READ    = 8'd17;
    localparam logic [7:0] CMD_WRITE   = 8'd24;

    localparam logic [7:0] TOK_DATA   = 8'hFE;
    localparam logic [7:0] BYTE_IDLE  = 8'hFF;
    localparam logic [7:0] CMD_CRC    = 8'h95;
    localparam logic [7:0] CMD_START  = 8'h40;
    localparam logic [3:0] RESP_OK    = 4'h5;

    typedef enum logic [4:0] {
        PH_IDLE, PH_WAKE, PH_CMD0, PH_CMD1, PH_CMDRW, PH_TOK0, PH_INIT,
        PH_RDTOK, PH_RDDATA, PH_RDCRC, PH_WRR1, PH_WRTOK, PH_WRDATA,
        PH_WRCRC, PH_WRRESP, PH_WRBUSY, PH_RELNEXT, PH_RELOPEN, PH_RELERR
    } t_phase;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] sector;
        logic [15:0] sector_count;
        logic [7:0]  miso_byte;
        logic [7:0]  write_data;
        logic        card_present;
        logic        write_protect;
    } t_req;

    typedef struct packed {
        logic [7:0] mosi_byte;
        logic       mosi_valid;
        logic       cs_active;
        logic [7:0] read_data;
        logic       read_valid;
        logic       done_res;
        logic       status;
        logic       card_open;
        logic       read_only;
        logic       busy_res;
    } t_res;

    function automatic logic [7:0] frame_byte(input logic [7:0] cmd,
                                              input logic [31:0] addr,
                                              input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            10'd1:   b = CMD_START | cmd;
            10'd2:   b = addr[31:24];
            10'd3:   b = addr[23:16];
            10'd4:   b = addr[15:8];
            10'd5:   b = addr[7:0];
            10'd6:   b = CMD_CRC;
            default: b = BYTE_IDLE;
        endcase
        return b;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/sdh_fifo.sv =====
// Small register queue used on the request and result sides.
// Depends on nothing but its parameters.
`default_nettype none
module sdh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (w_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
        if (w_push) r_mem[r_wp] <= i_data;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue count overflow");
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> r_cnt == $past(r_cnt) - 1'b1) else $error("pop lost");
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_cnt == $past(r_cnt) + 1'b1) else $error("push lost");
endmodule
`default_nettype wire

// ===== rtl/sdh_seq.sv =====
// Back end: the card sequencer, one request item per cycle while i_valid is high, into one result.
// Uses sdh_pkg.
`default_nettype none
module sdh_seq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [15:0]    i_cfg_data,
    input  wire logic           i_valid,
    input  wire sdh_pkg::t_req  i_req,
    output sdh_pkg::t_res       o_res
);
    import sdh_pkg::*;

    t_phase            r_phase, n_phase;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [15:0]       r_poll, n_poll, r_limit;
    logic [31:0]       r_addr, n_addr;
    logic [15:0]       r_left, n_left;
    logic              r_open, n_open, r_ro, n_ro;
    logic [1:0]        r_kind, n_kind;
    t_res              res;
    logic [15:0]       w_lim, w_pinc;
    logic              w_pout;
    logic [7:0]        w_cmd;
    logic [31:0]       w_faddr;

    assign w_lim  = (r_limit == '0) ? 16'd1 : r_limit;
    assign w_pinc = r_poll + 16'd1;
    assign w_pout = (w_pinc >= w_lim) || (w_pinc == '0);

    always_comb begin
        n_phase = r_phase; n_idx = r_idx; n_poll = r_poll; n_addr = r_addr;
        n_left = r_left; n_open = r_open; n_ro = r_ro; n_kind = r_kind;
        res = '0;
        w_cmd = CMD_GO_IDLE; w_faddr = '0;
        if (i_valid) begin
            if (r_phase != PH_IDLE) begin
                if (i_req.req_type == REQ_XCHG) begin
                    res.mosi_valid = 1'b1;
                    res.cs_active  = 1'b1;
                    res.mosi_byte  = BYTE_IDLE;
                    n_idx = '0;
                    unique case (r_phase)
                        PH_WAKE: begin
                            if (r_idx + 1'b1 < IDX_W'(IDLE_BYTES)) begin
                                n_idx = r_idx + 1'b1; res.cs_active = 1'b0;
                            end else begin
                                n_phase = PH_CMD0; n_poll = '0;
                                res.mosi_byte = frame_byte(CMD_GO_IDLE, '0, '0);
                            end
                        end
                        PH_CMD0, PH_CMD1, PH_CMDRW: begin
                            if (r_phase == PH_CMD1) w_cmd = CMD_INIT;
                            if (r_phase == PH_CMDRW) begin
                                w_cmd = (r_kind == 2'd1) ? CMD_READ : CMD_WRITE;
                                w_faddr = {r_addr[22:0], 9'd0};
                            end
                            if (r_idx < IDX_W'(7)) begin
                                n_idx = r_idx + 1'b1;
                                res.mosi_byte = frame_byte(w_cmd, w_faddr, n_idx);
                            end else begin
                                n_poll = '0;
                                if (r_phase == PH_CMD0) n_phase = PH_TOK0;
                                else if (r_phase == PH_CMD1) n_phase = PH_INIT;
                                else n_phase = (r_kind == 2'd1) ? PH_RDTOK : PH_WRR1;
                            end
                        end
                        PH_TOK0: begin
                            if (i_req.miso_byte != BYTE_IDLE) begin
                                n_poll = '0;
                                n_phase = (i_req.miso_byte == 8'd1) ? PH_INIT : PH_RELERR;
                            end else if (w_pout) begin
                                n_poll = '0; n_phase = PH_RELERR;
                            end else begin
                                n_poll = w_pinc; n_idx = r_idx;
                            end
                        end
                        PH_INIT: begin
                            if (i_req.miso_byte == 8'd0) begin
                                n_poll = '0; n_phase = PH_RELOPEN;
                            end else if (w_pout) begin
                                n_poll = '0; n_phase = PH_RELERR;
                            end else begin
                                n_poll = w_pinc; n_phase = PH_CMD1;
                            end
                        end
                        PH_RDTOK, PH_WRR1: begin
                            if ((r_phase == PH_RDTOK && i_req.miso_byte == TOK_DATA) ||
                                (r_phase == PH_WRR1 && i_req.miso_byte == 8'd0)) begin
                                n_poll = '0;
                                n_phase = (r_phase == PH_RDTOK) ? PH_RDDATA : PH_WRTOK;
                                if (r_phase == PH_WRR1) res.mosi_byte = TOK_DATA;
                            end else if (w_pout) begin
                                n_poll = '0; n_phase = PH_RELERR;
                            end else begin
                                n_poll = w_pinc; n_idx = r_idx;
                            end
                        end
                        PH_RDDATA: begin
                            res.read_data = i_req.miso_byte;
                            res.read_valid = 1'b1;
                            if (r_idx + 1'b1 < IDX_W'(SECTOR_BYTES)) n_idx = r_idx + 1'b1;
                            else begin n_phase = PH_RDCRC; n_poll = '0; end
                        end
                        PH_RDCRC, PH_WRCRC: begin
                            if (r_idx == '0) n_idx = IDX_W'(1);
                            else begin
                                n_poll = '0;
                                n_phase = (r_phase == PH_RDCRC) ? PH_RELNEXT : PH_WRRESP;
                            end
                        end
                        PH_WRTOK: begin
                            n_phase = PH_WRDATA;
                            res.mosi_byte = i_req.write_data;
                        end
                        PH_WRDATA: begin
                            if (r_idx + 1'b1 < IDX_W'(SECTOR_BYTES)) begin
                                n_idx = r_idx + 1'b1;
                                res.mosi_byte = i_req.write_data;
                            end else begin n_phase = PH_WRCRC; n_poll = '0; end
                        end
                        PH_WRRESP: begin
                            n_poll = '0;
                            n_phase = (i_req.miso_byte[3:0] == RESP_OK) ? PH_WRBUSY
                                                                        : PH_RELERR;
                        end
                        PH_WRBUSY: begin
                            if (i_req.miso_byte != 8'd0 || w_pout) begin
                                n_poll = '0; n_phase = PH_RELNEXT;
                            end else begin
                                n_poll = w_pinc; n_idx = r_idx;
                            end
                        end
                        PH_RELNEXT, PH_RELOPEN, PH_RELERR: begin
                            if (r_idx < IDX_W'(9)) n_idx = r_idx + 1'b1;
                            else if (r_phase == PH_RELERR) begin
                                res = '0; res.done_res = 1'b1; res.status = 1'b1;
                                n_phase = PH_IDLE;
                            end else if (r_phase == PH_RELOPEN) begin
                                res = '0; res.done_res = 1'b1;
                                n_open = 1'b1; n_ro = i_req.write_protect;
                                n_phase = PH_IDLE;
                            end else begin
                                n_addr = r_addr + 32'd1;
                                n_left = r_left - 16'd1;
                                if (n_left == '0) begin
                                    res = '0; res.done_res = 1'b1; n_phase = PH_IDLE;
                                end else begin
                                    n_phase = PH_CMDRW; n_poll = '0;
                                    res.mosi_byte = frame_byte(CMD_GO_IDLE, '0, '0);
                                end
                            end
                        end
                        default: begin
                            res = '0; n_phase = PH_IDLE; n_idx = r_idx;
                        end
                    endcase
                end
            end else begin
                unique case (i_req.req_type)
                    REQ_OPEN: begin
                        if (r_open) res.done_res = 1'b1;
                        else if (!i_req.card_present) begin
                            res.done_res = 1'b1; res.status = 1'b1;
                        end else begin
                            n_kind = 2'd0; n_phase = PH_WAKE; n_idx = '0; n_poll = '0;
                            res.mosi_valid = 1'b1; res.mosi_byte = BYTE_IDLE;
                        end
                    end
                    REQ_READ, REQ_WRITE: begin
                        if (!i_req.card_present ||
                            (i_req.req_type == REQ_WRITE && i_req.write_protect)) begin
                            res.done_res = 1'b1; res.status = 1'b1;
                        end else if (i_req.sector_count == '0) res.done_res = 1'b1;
                        else begin
                            n_kind = i_req.req_type[1:0];
                            n_addr = i_req.sector; n_left = i_req.sector_count;
                            n_phase = PH_CMDRW; n_idx = '0; n_poll = '0;
                            res.mosi_valid = 1'b1; res.cs_active = 1'b1;
                            res.mosi_byte = BYTE_IDLE;
                        end
                    end
                    REQ_CLOSE: begin
                        n_open = 1'b0; res.done_res = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        res.card_open = n_open;
        res.read_only = n_ro;
        res.busy_res  = (n_phase != PH_IDLE);
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_idx <= '0; r_poll <= '0; r_addr <= '0;
            r_left <= '0; r_open <= 1'b0; r_ro <= 1'b0; r_kind <= '0;
            r_limit <= 16'hFFFF;
        end else begin
            r_phase <= n_phase; r_idx <= n_idx; r_poll <= n_poll; r_addr <= n_addr;
            r_left <= n_left; r_open <= n_open; r_ro <= n_ro; r_kind <= n_kind;
            if (i_cfg_we) r_limit <= i_cfg_data;
        end
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && res.done_res) |=> r_phase == PH_IDLE) else $error("done not idle");
    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.status |-> res.done_res) else $error("status without done");
    a_read_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.read_valid |-> r_phase == PH_RDDATA) else $error("read byte out of phase");
endmodule
`default_nettype wire

// ===== rtl/sd_spi_sector_host.sv =====
// SPI-mode SD sector host. Every request and every exchanged byte is one
// input item; each yields exactly one result item.
// Channels: push/full in, empty/pop out, both queue-like.
// A two-entry request queue feeds the sequencer; each popped request is
// processed combinationally and its result goes to a two-entry result queue.
// A request is registered in the request queue, its result in the result
// queue, and the result then stays on the output ports until popped.
// Throughput: one item per cycle while results are taken; the sequencer
// step (next-byte decision) sets that rate.
// When pop stays low the result queue fills, the sequencer stops, and
// full rises once the request queue fills too; nothing is lost.
// Reset (synchronous, active low) empties both queues, returns the
// sequencer to idle, closes the card and sets timeout_limit to 65535.
// timeout_limit is written through i_cfg_we/i_cfg_data; the user must do so
// only while idle; the block does not enforce it. Depends on sdh_pkg, sdh_fifo, sdh_seq.
`default_nettype none
module sd_spi_sector_host (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [31:0] i_sector,
    input  wire logic [15:0] i_sector_count,
    input  wire logic [7:0]  i_miso_byte,
    input  wire logic [7:0]  i_write_data,
    input  wire logic        i_card_present,
    input  wire logic        i_write_protect,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_mosi_byte,
    output logic             o_mosi_valid,
    output logic             o_cs_active,
    output logic [7:0]       o_read_data,
    output logic             o_read_valid,
    output logic             o_done_res,
    output logic             o_status,
    output logic             o_card_open,
    output logic             o_read_only,
    output logic             o_busy_res
);
    import sdh_pkg::*;

    t_req w_in, w_req;
    t_res w_res, w_out;
    logic w_qempty, w_rfull, w_go;

    assign w_in = '{i_req_type, i_sector, i_sector_count, i_miso_byte,
                    i_write_data, i_card_present, i_write_protect};
    assign w_go = !w_qempty && !w_rfull;

    sdh_fifo #(.WIDTH($bits(t_req)), .DEPTH(2)) u_reqq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(w_in),
        .o_full(full), .i_pop(w_go), .o_empty(w_qempty), .o_data(w_req));

    sdh_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data), .i_valid(w_go), .i_req(w_req), .o_res(w_res));

    sdh_fifo #(.WIDTH($bits(t_res)), .DEPTH(2)) u_resq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_go), .i_data(w_res),
        .o_full(w_rfull), .i_pop(pop), .o_empty(empty), .o_data(w_out));

    assign o_mosi_byte  = w_out.mosi_byte;
    assign o_mosi_valid = w_out.mosi_valid;
    assign o_cs_active  = w_out.cs_active;
    assign o_read_data  = w_out.read_data;
    assign o_read_valid = w_out.read_valid;
    assign o_done_res   = w_out.done_res;
    assign o_status     = w_out.status;
    assign o_card_open  = w_out.card_open;
    assign o_read_only  = w_out.read_only;
    assign o_busy_res   = w_out.busy_res;
endmodule
`default_nettype wire

// ===== bench/sd_spi_sector_host_tb.sv =====
// Self-checking testbench for sd_spi_sector_host: a scripted SD card answers
// each request, a predictor works out every result, a monitor compares them.
// Depends on sdh_pkg and the sd_spi_sector_host RTL.
`default_nettype none
module sd_spi_sector_host_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sdh_pkg::*;

    localparam int STALL_LIMIT = 4000;

    typedef struct {
        t_phase      ph;
        logic [9:0]  idx;
        logic [15:0] polls;
        logic [31:0] addr;
        logic [15:0] left;
        logic        open_f;
        logic        ro_f;
        logic [1:0]  kind;
        logic [15:0] tlim;
    } t_host;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;
    logic        push;
    logic        full;
    logic        empty;
    logic        pop;
    t_req        drv;
    t_res        got;

    t_req  pend_q[$];
    t_res  want_q[$];
    t_host card_side;
    t_host host_side;
    int    fails;
    int    idle_cycles;
    int    burst_left;
    int    gap_left;
    int    pop_pct;
    int    pop_cycles;
    int    phase_items;

    sd_spi_sector_host dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .push(push), .full(full),
        .i_req_type(drv.req_type), .i_sector(drv.sector),
        .i_sector_count(drv.sector_count), .i_miso_byte(drv.miso_byte),
        .i_write_data(drv.write_data), .i_card_present(drv.card_present),
        .i_write_protect(drv.write_protect),
        .empty(empty), .pop(pop),
        .o_mosi_byte(got.mosi_byte), .o_mosi_valid(got.mosi_valid),
        .o_cs_active(got.cs_active), .o_read_data(got.read_data),
        .o_read_valid(got.read_valid), .o_done_res(got.done_res),
        .o_status(got.status), .o_card_open(got.card_open),
        .o_read_only(got.read_only), .o_busy_res(got.busy_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_host host_reset();
        t_host m;
        m.ph = PH_IDLE;
        m.idx = '0;
        m.polls = '0;
        m.addr = '0;
        m.left = '0;
        m.open_f = 1'b0;
        m.ro_f = 1'b0;
        m.kind = '0;
        m.tlim = 16'hFFFF;
        return m;
    endfunction

    function automatic void send_byte(inout t_res o, input logic [7:0] b, input logic cs);
        o.mosi_byte = b;
        o.mosi_valid = 1'b1;
        o.cs_active = cs;
    endfunction

    function automatic logic [7:0] cmd_frame(t_host m);
        logic [7:0]  cmd;
        logic [31:0] a;
        cmd = CMD_GO_IDLE;
        a = '0;
        if (m.ph == PH_CMD1) cmd = CMD_INIT;
        if (m.ph == PH_CMDRW) begin
            cmd = (m.kind == REQ_READ[1:0]) ? CMD_READ : CMD_WRITE;
            a = m.addr << 9;
        end
        case (m.idx)
            10'd1: return CMD_START | cmd;
            10'd2: return a[31:24];
            10'd3: return a[23:16];
            10'd4: return a[15:8];
            10'd5: return a[7:0];
            10'd6: return CMD_CRC;
            default: return BYTE_IDLE;
        endcase
    endfunction

    function automatic void enter(inout t_host m, inout t_res o, input t_phase p);
        m.ph = p;
        m.idx = '0;
        m.polls = '0;
        if (p == PH_CMD0 || p == PH_CMD1 || p == PH_CMDRW) send_byte(o, cmd_frame(m), 1'b1);
        else send_byte(o, (p == PH_WRTOK) ? TOK_DATA : BYTE_IDLE, p != PH_WAKE);
    endfunction

    function automatic void complete(inout t_host m, inout t_res o, input logic err);
        m.ph = PH_IDLE;
        m.idx = '0;
        o.done_res = 1'b1;
        o.status = err;
    endfunction

    // count one unmatched answer; true once the wait has run out
    function automatic bit wait_expired(inout t_host m);
        logic [15:0] lim;
        lim = (m.tlim == 0) ? 16'd1 : m.tlim;
        m.polls = m.polls + 16'd1;
        return m.polls >= lim || m.polls == 0;
    endfunction

    function automatic t_res host_step(inout t_host m, input t_req r);
        t_res        o;
        logic [15:0] keep;
        o = '0;
        if (m.ph != PH_IDLE) begin
            if (r.req_type == REQ_XCHG) begin
                case (m.ph)
                    PH_WAKE:
                        if (m.idx + 1 < IDLE_BYTES) begin
                            m.idx++;
                            send_byte(o, BYTE_IDLE, 1'b0);
                        end else enter(m, o, PH_CMD0);
                    PH_CMD0, PH_CMD1, PH_CMDRW:
                        if (m.idx < 7) begin
                            m.idx++;
                            send_byte(o, cmd_frame(m), 1'b1);
                        end else if (m.ph == PH_CMD0) enter(m, o, PH_TOK0);
                        else if (m.ph == PH_CMD1) enter(m, o, PH_INIT);
                        else enter(m, o, (m.kind == REQ_READ[1:0]) ? PH_RDTOK : PH_WRR1);
                    PH_TOK0:
                        if (r.miso_byte != BYTE_IDLE)
                            enter(m, o, (r.miso_byte == 8'd1) ? PH_INIT : PH_RELERR);
                        else if (wait_expired(m)) enter(m, o, PH_RELERR);
                        else send_byte(o, BYTE_IDLE, 1'b1);
                    PH_INIT:
                        if (r.miso_byte == 8'd0) enter(m, o, PH_RELOPEN);
                        else if (wait_expired(m)) enter(m, o, PH_RELERR);
                        else begin
                            // resend CMD1 but keep the poll count running
                            keep = m.polls;
                            enter(m, o, PH_CMD1);
                            m.polls = keep;
                        end
                    PH_RDTOK:
                        if (r.miso_byte == TOK_DATA) enter(m, o, PH_RDDATA);
                        else if (wait_expired(m)) enter(m, o, PH_RELERR);
                        else send_byte(o, BYTE_IDLE, 1'b1);
                    PH_RDDATA: begin
                        o.read_data = r.miso_byte;
                        o.read_valid = 1'b1;
                        if (m.idx + 1 < SECTOR_BYTES) begin
                            m.idx++;
                            send_byte(o, BYTE_IDLE, 1'b1);
                        end else enter(m, o, PH_RDCRC);
                    end
                    PH_RDCRC, PH_WRCRC:
                        if (m.idx == 0) begin
                            m.idx = 10'd1;
                            send_byte(o, BYTE_IDLE, 1'b1);
                        end else enter(m, o, (m.ph == PH_RDCRC) ? PH_RELNEXT : PH_WRRESP);
                    PH_WRR1:
                        if (r.miso_byte == 8'd0) enter(m, o, PH_WRTOK);
                        else if (wait_expired(m)) enter(m, o, PH_RELERR);
                        else send_byte(o, BYTE_IDLE, 1'b1);
                    PH_WRTOK: begin
                        m.ph = PH_WRDATA;
                        m.idx = '0;
                        send_byte(o, r.write_data, 1'b1);
                    end
                    PH_WRDATA:
                        if (m.idx + 1 < SECTOR_BYTES) begin
                            m.idx++;
                            send_byte(o, r.write_data, 1'b1);
                        end else enter(m, o, PH_WRCRC);
                    PH_WRRESP:
                        enter(m, o, (r.miso_byte[3:0] == RESP_OK) ? PH_WRBUSY : PH_RELERR);
                    PH_WRBUSY:
                        if (r.miso_byte != 8'd0 || wait_expired(m)) enter(m, o, PH_RELNEXT);
                        else send_byte(o, BYTE_IDLE, 1'b1);
                    PH_RELNEXT, PH_RELOPEN, PH_RELERR:
                        if (m.idx < 9) begin
                            m.idx++;
                            send_byte(o, BYTE_IDLE, 1'b1);
                        end else if (m.ph == PH_RELERR) complete(m, o, 1'b1);
                        else if (m.ph == PH_RELOPEN) begin
                            m.open_f = 1'b1;
                            m.ro_f = r.write_protect;
                            complete(m, o, 1'b0);
                        end else begin
                            m.addr = m.addr + 32'd1;
                            m.left = m.left - 16'd1;
                            if (m.left == 0) complete(m, o, 1'b0);
                            else enter(m, o, PH_CMDRW);
                        end
                    default: m.ph = PH_IDLE;
                endcase
            end
        end else if (r.req_type == REQ_OPEN) begin
            if (m.open_f) complete(m, o, 1'b0);
            else if (!r.card_present) complete(m, o, 1'b1);
            else begin
                m.kind = '0;
                enter(m, o, PH_WAKE);
            end
        end else if (r.req_type == REQ_READ || r.req_type == REQ_WRITE) begin
            if (!r.card_present || (r.req_type == REQ_WRITE && r.write_protect))
                complete(m, o, 1'b1);
            else if (r.sector_count == 0) complete(m, o, 1'b0);
            else begin
                m.kind = r.req_type[1:0];
                m.addr = r.sector;
                m.left = r.sector_count;
                enter(m, o, PH_CMDRW);
            end
        end else if (r.req_type == REQ_CLOSE) begin
            m.open_f = 1'b0;
            complete(m, o, 1'b0);
        end
        o.card_open = m.open_f;
        o.read_only = m.ro_f;
        o.busy_res = (m.ph != PH_IDLE);
        return o;
    endfunction

    // card answer: 0 cooperative, 1 random bytes, 2 cooperative but rejects data
    function automatic logic [7:0] card_reply(t_host m, int mode);
        logic [7:0] any;
        any = $urandom;
        if (mode == 1) return any;
        case (m.ph)
            PH_TOK0:   return ($urandom_range(0, 2) == 0) ? 8'd1 : BYTE_IDLE;
            PH_INIT:   return ($urandom_range(0, 2) == 0) ? 8'd0 : (any | 8'd1);
            PH_RDTOK:  return ($urandom_range(0, 3) == 0) ? TOK_DATA : BYTE_IDLE;
            PH_WRR1:   return ($urandom_range(0, 2) == 0) ? 8'd0 : (any | 8'd1);
            PH_WRRESP: return (mode == 2) ? {any[7:4], 4'hB} : {any[7:4], RESP_OK};
            PH_WRBUSY: return ($urandom_range(0, 2) == 0) ? (any | 8'd1) : 8'd0;
            default:   return any;
        endcase
    endfunction

    function automatic t_req rand_item(logic [2:0] kind);
        t_req r;
        r.req_type = kind;
        r.sector = $urandom;
        r.sector_count = $urandom;
        r.miso_byte = $urandom;
        r.write_data = $urandom;
        r.card_present = $urandom;
        r.write_protect = $urandom;
        return r;
    endfunction

    task automatic add_item(t_req r);
        t_res unused;
        pend_q.push_back(r);
        unused = host_step(card_side, r);
        phase_items++;
    endtask

    // one request, then exchanges until the card side is idle again
    task automatic run_request(logic [2:0] kind, logic [31:0] sec, logic [15:0] cnt,
                               logic cd, logic wp, int mode);
        t_req r;
        r = rand_item(kind);
        r.sector = sec;
        r.sector_count = cnt;
        r.card_present = cd;
        r.write_protect = wp;
        add_item(r);
        while (card_side.ph != PH_IDLE) begin
            // drop in a request the busy sequencer has to ignore
            if ($urandom_range(0, 40) == 0) begin
                r = rand_item($urandom_range(0, 3));
                if ($urandom_range(0, 1) == 0) r.req_type = $urandom_range(5, 7);
                add_item(r);
            end
            r = rand_item(REQ_XCHG);
            r.miso_byte = card_reply(card_side, mode);
            add_item(r);
        end
    endtask

    // sector transfers run here only against a short timeout and a noisy
    // card, so most of them give up early and the item count stays small
    task automatic random_requests(int count);
        int   pick;
        int   mode;
        t_req r;
        phase_items = 0;
        while (phase_items < count) begin
            pick = $urandom_range(0, 19);
            mode = 0;
            if (card_side.tlim <= 40 && $urandom_range(0, 3) == 0) mode = 1;
            else if ($urandom_range(0, 5) == 0) mode = 2;
            if (pick < 6) run_request(REQ_OPEN, $urandom, $urandom, $urandom_range(0, 8) != 0,
                                      $urandom, mode);
            else if (pick < 9) run_request(REQ_CLOSE, $urandom, $urandom, $urandom, $urandom, 0);
            else if (pick == 9 && card_side.tlim <= 40)
                run_request(REQ_READ, $urandom, 16'd1, 1'b1, $urandom, 1);
            else if (pick == 10 && card_side.tlim <= 40)
                run_request(REQ_WRITE, $urandom, 16'd1, 1'b1, 1'b0, 1);
            else if (pick < 14) run_request($urandom_range(1, 2), $urandom, 16'd0, 1'b1,
                                            1'b0, 0);
            else if (pick < 17) run_request($urandom_range(1, 2), $urandom, $urandom, 1'b0,
                                            $urandom, 0);
            else if (pick < 19) run_request(REQ_WRITE, $urandom, $urandom, 1'b1, 1'b1, 0);
            else begin
                r = rand_item($urandom_range(4, 7));
                add_item(r);
            end
        end
    endtask

    // hold until every request has come back, then write the timeout
    task automatic set_timeout(logic [15:0] value);
        while (pend_q.size() != 0 || want_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        host_side.tlim = value;
        card_side.tlim = value;
    endtask

    initial begin
        logic [15:0] limits[5];
        t_req        r;
        limits = '{16'd1, 16'd0, 16'd4, 16'd17, 16'hFFFF};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        fails = 0;
        card_side = host_reset();
        host_side = host_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_timeout(16'hFFFF);

        phase_items = 0;
        r = rand_item(3'd7);
        add_item(r);
        r = rand_item(REQ_XCHG);
        add_item(r);
        run_request(REQ_OPEN, '0, '0, 1'b0, 1'b0, 0);
        run_request(REQ_READ, '0, 16'd1, 1'b0, 1'b0, 0);
        run_request(REQ_WRITE, '0, 16'd1, 1'b1, 1'b1, 0);
        run_request(REQ_READ, 32'hFFFFFFFF, 16'd0, 1'b1, 1'b0, 0);
        run_request(REQ_OPEN, '0, '0, 1'b1, 1'b1, 0);
        run_request(REQ_OPEN, '0, '0, 1'b1, 1'b0, 0);
        run_request(REQ_READ, 32'd0, 16'd1, 1'b1, 1'b0, 0);
        run_request(REQ_WRITE, 32'h007FFFFF, 16'd1, 1'b1, 1'b0, 2);
        run_request(REQ_CLOSE, '0, '0, 1'b0, 1'b0, 0);

        foreach (limits[k]) begin
            set_timeout(limits[k]);
            random_requests(25);
        end
        set_timeout($urandom_range(2, 40));
        random_requests(25);

        while (pend_q.size() != 0 || want_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fails == 0) $display("[sd_spi_sector_host] OK");
        else $display("[sd_spi_sector_host] ERROR");
        $finish;
    end

    // sender: bursts of requests separated by random gaps
    always @(posedge i_clk) begin
        logic nxt;
        if (!i_rst_n) begin
            push <= 1'b0;
            drv <= '0;
            burst_left = 1;
            gap_left = 0;
        end else begin
            nxt = 1'b0;
            if (push && !full) begin
                want_q.push_back(host_step(host_side, pend_q.pop_front()));
            end
            if (push && full) nxt = 1'b1;
            else if (gap_left > 0) gap_left--;
            else if (pend_q.size() > 0) begin
                nxt = 1'b1;
                drv <= pend_q[0];
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 60);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            push <= nxt;
        end
    end

    task automatic check_field(string name, int want, int seen);
        if (want != seen) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            fails++;
        end
    endtask

    // receiver: checks every popped result against the predictor; the pop rate is redrawn at random
    always @(posedge i_clk) begin
        t_res w;
        if (!i_rst_n) begin
            pop <= 1'b0;
            pop_pct = 100;
            pop_cycles = 0;
        end else begin
            if (pop && !empty) begin
                if (want_q.size() == 0) begin
                    $error("result with no request outstanding");
                    fails++;
                end else begin
                    w = want_q.pop_front();
                    check_field("mosi_byte", w.mosi_byte, got.mosi_byte);
                    check_field("mosi_valid", w.mosi_valid, got.mosi_valid);
                    check_field("cs_active", w.cs_active, got.cs_active);
                    check_field("read_data", w.read_data, got.read_data);
                    check_field("read_valid", w.read_valid, got.read_valid);
                    check_field("done_res", w.done_res, got.done_res);
                    check_field("status", w.status, got.status);
                    check_field("card_open", w.card_open, got.card_open);
                    check_field("read_only", w.read_only, got.read_only);
                    check_field("busy_res", w.busy_res, got.busy_res);
                end
            end
            pop_cycles++;
            if (pop_cycles >= 300) begin
                pop_cycles = 0;
                pop_pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(20, 90);
            end
            pop <= ($urandom_range(1, 100) <= pop_pct);
        end
    end

    // watchdog: cycles with no request and no result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("[sd_spi_sector_host] ERROR");
            $finish;
        end else idle_cycles <= idle_cycles + 1;
    end
endmodule
`default_nettype wire
